/* rtl/gb3_pkg.sv */
package gb3_pkg;

  // Fixed field widths of the stream and the configuration port
  localparam int PIX_IN_W  = 8;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 10;
  localparam int WIDTH_W   = 11;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 12;

  // Depth of the queue between the window front and the summing back end
  localparam int QDEPTH = 4;

  // Reset frame size
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  // Position tag that travels with every interior result
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } pos_t;

endpackage

/* rtl/gb3_fifo.sv */
module gb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   fill;

  assign pop_data = slots[rd_ptr];
  assign empty    = (fill == '0);
  assign count    = fill;

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNW'(1);
      end
    end
  end

endmodule

/* rtl/gb3_front.sv */
module gb3_front
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int PW        = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIX_IN_W-1:0]          pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] width_last,
  input  logic [ROW_W-1:0]             height_last,
  input  logic [$clog2(QDEPTH+1)-1:0]  q_count,
  output logic                         push,
  output logic [PW+3:0]                push_side,
  output logic [PW+1:0]                push_col,
  output pos_t                         push_pos
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int QCW = $clog2(QDEPTH + 1) + 1;

  // Line stores: one read at accept, one write in the cycle after
  logic [PW-1:0] upper_mem  [MAX_WIDTH];
  logic [PW-1:0] middle_mem [MAX_WIDTH];

  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             accept;
  logic             col_wrap;
  logic             row_wrap;
  logic [CW-1:0]    col_m1;

  // Read stage registers
  logic             s1_valid;
  logic             s1_emit;
  logic [CW-1:0]    s1_idx;
  logic [PW-1:0]    s1_px;
  pos_t             s1_pos;
  logic [PW-1:0]    top_rd;
  logic [PW-1:0]    mid_rd;

  // Window held as weighted column sums, oldest first
  logic [PW+1:0]    cs_old;
  logic [PW+1:0]    cs_mid;
  logic [PW+1:0]    cs_new;

  assign in_ready = (QCW'(q_count) + QCW'(s1_valid)) < QCW'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign col_wrap = (col >= width_last);
  assign row_wrap = (row >= height_last);
  assign col_m1   = col - CW'(1);

  // Step the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Read the two rows above; write back the shifted column in the cycle after
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= upper_mem[col];
      mid_rd <= middle_mem[col];
    end
    if (s1_valid) begin
      upper_mem[s1_idx]  <= mid_rd;
      middle_mem[s1_idx] <= s1_px;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx       <= col;
      s1_px        <= pixel[PW-1:0];
      s1_emit      <= (row >= ROW_W'(2)) && (col >= CW'(2));
      s1_pos.row   <= row - ROW_W'(1);
      s1_pos.col   <= COL_OUT_W'(col_m1);
      s1_pos.last  <= row_wrap && col_wrap;
    end
  end

  // Weighted sum of the newest column: top + 2*mid + bottom
  assign cs_new = (PW+2)'(top_rd) + {1'b0, mid_rd, 1'b0} + (PW+2)'(s1_px);

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_old <= '0;
      cs_mid <= '0;
    end else if (s1_valid) begin
      cs_old <= cs_mid;
      cs_mid <= cs_new;
    end
  end

  // Hand interior results to the queue
  assign push      = s1_valid && s1_emit;
  assign push_side = (PW+4)'(cs_old) + {1'b0, cs_mid, 1'b0};
  assign push_col  = cs_new;
  assign push_pos  = s1_pos;

endmodule

/* rtl/gb3_back.sv */
module gb3_back
  import gb3_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [PW+3:0]         q_side,
  input  logic [PW+1:0]         q_col,
  input  pos_t                  q_pos,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_IN_W-1:0]   blurred,
  output logic [ROW_W-1:0]      centre_row,
  output logic [COL_OUT_W-1:0]  centre_col,
  output logic                  frame_last
);

  logic [PW+3:0] sum;

  // Take the next entry when the output register is free or draining
  assign q_pop = !q_empty && (!out_valid || out_ready);
  assign sum   = q_side + (PW+4)'(q_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Divide by 16 and hold the result until taken
  always_ff @(posedge clk) begin
    if (q_pop) begin
      blurred    <= PIX_IN_W'(sum[PW+3:4]);
      centre_row <= q_pos.row;
      centre_col <= q_pos.col;
      frame_last <= q_pos.last;
    end
  end

endmodule

/* rtl/gaussian_blur_3x3_top.sv */
// 3x3 Gaussian blur (weights 1 2 1 / 2 4 2 / 1 2 1, sum divided by 16 and
// truncated) over a raster pixel stream. One pixel is taken per clock while
// in_ready is high; the rate is set by the two line stores, which each do one
// read and one write per pixel on separate ports. A result for interior pixel
// (r-1, c-1) passes the read stage registers, the queue and the output register
// to out_valid; border pixels give no result. The user must write image_width
// (clamped to 3..MAX_WIDTH) and image_height (clamped to at least 3) via the cfg
// port only while the stream is idle; this is not enforced. Line store contents
// are undefined after reset and are filled by the first two rows of each frame.
module gaussian_blur_3x3_top
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_IN_W-1:0]   pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_IN_W-1:0]   blurred,
  output logic [ROW_W-1:0]      centre_row,
  output logic [COL_OUT_W-1:0]  centre_col,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  localparam int PW  = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int QW  = $bits(pos_t) + 2 * PW + 6;
  localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  logic [CW-1:0]    width_last;
  logic [ROW_W-1:0] height_last;
  logic             cfg_write;
  logic [13:0]      w_req;
  logic [13:0]      w_eff;
  logic [ROW_W-1:0] h_req;
  logic [ROW_W-1:0] h_eff;

  logic                        push;
  logic [PW+3:0]               push_side;
  logic [PW+1:0]               push_col;
  pos_t                        push_pos;
  logic                        q_pop;
  logic                        q_empty;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  logic [QW-1:0]               q_data;
  logic [PW+3:0]               q_side;
  logic [PW+1:0]               q_col;
  pos_t                        q_pos;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Clamp the frame size on write and keep the last column and row
  assign w_req = 14'(cfg_data[WIDTH_W-1:0]);
  assign w_eff = (w_req < 14'd3) ? 14'd3 : ((w_req > MAXW) ? MAXW : w_req);
  assign h_req = cfg_data[ROW_W-1:0];
  assign h_eff = (h_req < ROW_W'(3)) ? ROW_W'(3) : h_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= CW'(RST_W - 1);
      height_last <= ROW_W'(RESET_HEIGHT - 1);
    end else if (cfg_write) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        width_last <= CW'(w_eff - 14'd1);
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        height_last <= h_eff - ROW_W'(1);
      end
    end
  end

  gb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .PW        (PW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .width_last  (width_last),
    .height_last (height_last),
    .q_count     (q_count),
    .push        (push),
    .push_side   (push_side),
    .push_col    (push_col),
    .push_pos    (push_pos)
  );

  gb3_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_side, push_col, push_pos}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  assign {q_side, q_col, q_pos} = q_data;

  gb3_back #(
    .PW (PW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_side     (q_side),
    .q_col      (q_col),
    .q_pos      (q_pos),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blurred    (blurred),
    .centre_row (centre_row),
    .centre_col (centre_col),
    .frame_last (frame_last)
  );

endmodule
